// ===== rtl/core/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants of the stream search and replace unit.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int MAX_LEN     = 32;
  localparam int MAX_RESULTS = 32;
  localparam int LEN_W       = 6;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 16;

  typedef enum logic [1:0] {
    FUNC_STREAM  = 2'd0,
    FUNC_EOS     = 2'd1,
    FUNC_PATTERN = 2'd2,
    FUNC_REPLACE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_PATTERN_LEN = 3'd0,
    REG_REPLACE_LEN = 3'd1,
    REG_REPLACE_EN  = 3'd2,
    REG_MIN_MATCHES = 3'd3,
    REG_MAX_MATCHES = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_TABLE,
    OP_SCAN,
    OP_EMIT_WIN,
    OP_EMIT_REP,
    OP_DROP,
    OP_FLUSH,
    OP_STATUS,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic empty;     // every buffered byte is part of the partial match
    logic full;      // this scan step completes a match
    logic do_rep;    // the completed match is replaced
    logic rem_one;   // last step of an emit or drop run
    logic w_zero;    // no partial match is pending
    logic stall;     // output side cannot take this step's result
  } sts_t;

  // Lengths of 0 act as 1, larger than the tables saturate.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) r = LEN_W'(1);
    else if (v > LEN_W'(MAX_LEN)) r = LEN_W'(MAX_LEN);
    return r;
  endfunction

endpackage

// ===== rtl/core/stream_search_replace_unit.sv =====
// ----------------------------------------------------------------------------
// stream_search_replace_unit
// Byte-stream search and replace with loadable pattern and replacement tables.
// ----------------------------------------------------------------------------
// Flow: a stream byte is loaded into the buffer, then the sequencer runs its scan,
// emit and drop steps and a closing step; each result passes through the hold
// stage to the output register. A new transfer is taken only once the item is done.
// An end of stream flushes every buffered byte, then emits a status result and
// closes. Table writes are taken while idle. A stalled output holds the sequencer.
// Reset (rst, synchronous): clears the match count, empties the byte buffer and restores the configuration defaults.
module stream_search_replace_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [12:8] table_index
  input  logic [1:0]  s_axis_tuser,  // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] out_byte, [23:8] match_count
  output logic [0:0]  m_axis_tuser,  // [0] byte_valid
  output logic        m_axis_tlast,  // last result of the input transfer
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ssr_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [7:0]       out_byte;
  logic             out_bv;
  logic [CNT_W-1:0] out_cnt;

  // The sequencer only accepts a transfer when the previous item is complete.
  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds one result back so that the last flag can be set on it
  // once the item is known to be finished.
  ssr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (s_axis_tuser),
    .in_byte   (s_axis_tdata[7:0]),
    .in_index  (s_axis_tdata[12:8]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (out_byte),
    .out_bv    (out_bv),
    .out_cnt   (out_cnt),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_cnt, out_byte};
  assign m_axis_tuser = out_bv;

endmodule

// ===== rtl/core/ssr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssr_ctrl
// Sequencer: steps the datapath through scan, emit, drop, flush, status and finish phases.
// ----------------------------------------------------------------------------
module ssr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    in_func,
  output logic          in_ready,
  input  ssr_pkg::sts_t sts,
  output ssr_pkg::cmd_t cmd
);
  import ssr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EMIT_WIN, S_EMIT_REP, S_DROP, S_FLUSH, S_STATUS, S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FUNC_STREAM: begin
              cmd.op     = OP_LOAD;
              state_next = S_SCAN;
            end
            FUNC_EOS: state_next = S_FLUSH;
            default: cmd.op = OP_TABLE;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.empty) begin
          state_next = S_FINISH;
        end else begin
          cmd.op = OP_SCAN;
          if (!sts.stall && sts.full) state_next = sts.do_rep ? S_EMIT_REP : S_EMIT_WIN;
        end
      end
      S_EMIT_WIN: begin
        cmd.op = OP_EMIT_WIN;
        if (!sts.stall && sts.rem_one) state_next = S_SCAN;
      end
      S_EMIT_REP: begin
        cmd.op = OP_EMIT_REP;
        if (!sts.stall && sts.rem_one) state_next = S_DROP;
      end
      S_DROP: begin
        cmd.op = OP_DROP;
        if (sts.rem_one) state_next = S_SCAN;
      end
      S_FLUSH: begin
        if (sts.w_zero) state_next = S_STATUS;
        else cmd.op = OP_FLUSH;
      end
      S_STATUS: begin
        cmd.op = OP_STATUS;
        if (!sts.stall) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.op = OP_FINISH;
        if (!sts.stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ===== rtl/core/ssr_dp.sv =====
// ----------------------------------------------------------------------------
// ssr_dp
// Datapath: tables, byte buffer, counters, result hold stage and output register.
// ----------------------------------------------------------------------------
module ssr_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  ssr_pkg::cmd_t              cmd,
  output ssr_pkg::sts_t              sts,
  input  logic [1:0]                 in_func,
  input  logic [7:0]                 in_byte,
  input  logic [ssr_pkg::IDX_W-1:0]  in_index,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [15:0]                cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_bv,
  output logic [ssr_pkg::CNT_W-1:0]  out_cnt,
  output logic                       out_last
);
  import ssr_pkg::*;

  logic [7:0]       pat [MAX_LEN];
  logic [7:0]       rep [MAX_LEN];
  logic [7:0]       win [MAX_LEN];
  logic [LEN_W-1:0] n, w, rem, res_cnt;
  logic [IDX_W-1:0] rep_idx;
  logic [CNT_W-1:0] match_total;

  logic [LEN_W-1:0] cfg_plen, cfg_rlen;
  logic             cfg_ren;
  logic [CNT_W-1:0] cfg_min, cfg_max;

  logic             hold_valid, hold_bv;
  logic [7:0]       hold_byte;
  logic [CNT_W-1:0] hold_cnt;

  logic [LEN_W-1:0] plen, rlen;
  logic [CNT_W-1:0] matches_inc;
  logic             allowed, is_match, full, do_rep;
  logic             emit_req, push_take, can_push, stall, go, move_out, shift;
  logic [7:0]       emit_byte;
  logic             emit_bv;

  assign plen        = eff_len(cfg_plen);
  assign rlen        = eff_len(cfg_rlen);
  assign allowed     = (cfg_max == '0) || (match_total < cfg_max);
  assign is_match    = ((w == '0) ? allowed : (w < plen)) &&
                       (win[w[IDX_W-1:0]] == pat[w[IDX_W-1:0]]);
  assign full        = is_match && ((w + LEN_W'(1)) == plen);
  assign matches_inc = (match_total == '1) ? match_total : match_total + CNT_W'(1);
  assign do_rep      = cfg_ren && !(matches_inc < cfg_min);

  always_comb begin
    emit_req  = 1'b0;
    emit_byte = win[0];
    emit_bv   = 1'b1;
    case (cmd.op)
      OP_SCAN:     emit_req = (w != n) && !is_match;
      OP_EMIT_WIN: emit_req = 1'b1;
      OP_FLUSH:    emit_req = 1'b1;
      OP_EMIT_REP: begin
        emit_req  = 1'b1;
        emit_byte = rep[rep_idx];
      end
      OP_STATUS: begin
        emit_req  = 1'b1;
        emit_byte = 8'd0;
        emit_bv   = 1'b0;
      end
      default: emit_req = 1'b0;
    endcase
  end

  assign can_push  = !out_valid || out_ready;
  assign push_take = emit_req && (res_cnt < LEN_W'(MAX_RESULTS));
  assign stall     = hold_valid && !can_push && (push_take || (cmd.op == OP_FINISH));
  assign go        = !stall;
  assign move_out  = go && hold_valid && (push_take || (cmd.op == OP_FINISH));
  assign shift     = go && ((cmd.op == OP_SCAN && emit_req) || cmd.op == OP_EMIT_WIN ||
                            cmd.op == OP_DROP || cmd.op == OP_FLUSH);

  assign sts.empty   = (w == n);
  assign sts.full    = full;
  assign sts.do_rep  = do_rep;
  assign sts.rem_one = (rem == LEN_W'(1));
  assign sts.w_zero  = (w == '0);
  assign sts.stall   = stall;

  // Tables and the byte buffer carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_TABLE) begin
      if (in_func == FUNC_PATTERN) pat[in_index] <= in_byte;
      else rep[in_index] <= in_byte;
    end
    if (cmd.op == OP_LOAD) begin
      win[n[IDX_W-1:0]] <= in_byte;
    end else if (shift) begin
      for (int i = 0; i < MAX_LEN - 1; i++) win[i] <= win[i+1];
    end
    if (go && push_take) begin
      hold_byte <= emit_byte;
      hold_bv   <= emit_bv;
      hold_cnt  <= match_total;
    end
    if (move_out) begin
      out_byte <= hold_byte;
      out_bv   <= hold_bv;
      out_cnt  <= hold_cnt;
      out_last <= (cmd.op == OP_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n           <= '0;
      w           <= '0;
      rem         <= '0;
      rep_idx     <= '0;
      res_cnt     <= '0;
      match_total <= '0;
      hold_valid  <= 1'b0;
      out_valid   <= 1'b0;
      cfg_plen    <= LEN_W'(1);
      cfg_rlen    <= LEN_W'(1);
      cfg_ren     <= 1'b0;
      cfg_min     <= CNT_W'(1);
      cfg_max     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_LEN: cfg_plen <= cfg_data[LEN_W-1:0];
          REG_REPLACE_LEN: cfg_rlen <= cfg_data[LEN_W-1:0];
          REG_REPLACE_EN:  cfg_ren  <= cfg_data[0];
          REG_MIN_MATCHES: cfg_min  <= cfg_data;
          REG_MAX_MATCHES: cfg_max  <= cfg_data;
          default: ;
        endcase
      end

      if (shift) n <= n - LEN_W'(1);
      if (cmd.op == OP_LOAD) n <= n + LEN_W'(1);

      if (go) begin
        case (cmd.op)
          OP_SCAN: begin
            if (w != n) begin
              if (!is_match) begin
                w <= '0;
              end else if (full) begin
                w           <= '0;
                match_total <= matches_inc;
                rep_idx     <= '0;
                rem         <= do_rep ? rlen : plen;
              end else begin
                w <= w + LEN_W'(1);
              end
            end
          end
          OP_EMIT_WIN, OP_DROP: rem <= rem - LEN_W'(1);
          OP_EMIT_REP: begin
            rep_idx <= rep_idx + IDX_W'(1);
            rem     <= (rem == LEN_W'(1)) ? plen : rem - LEN_W'(1);
          end
          OP_FLUSH: w <= w - LEN_W'(1);
          default: ;
        endcase
      end

      if (go && push_take) begin
        hold_valid <= 1'b1;
        res_cnt    <= res_cnt + LEN_W'(1);
      end
      if (go && cmd.op == OP_FINISH) begin
        hold_valid <= 1'b0;
        res_cnt    <= '0;
      end

      if (move_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_w_within_buffer: assert property (@(posedge clk) disable iff (rst) w <= n)
    else $error("partial match runs past the buffered bytes");
  a_buffer_bound: assert property (@(posedge clk) disable iff (rst) n <= LEN_W'(MAX_LEN))
    else $error("byte buffer overfilled");
  a_result_bound: assert property (@(posedge clk) disable iff (rst)
      res_cnt <= LEN_W'(MAX_RESULTS))
    else $error("too many results for one item");
  a_finish_empties: assert property (@(posedge clk) disable iff (rst)
      (cmd.op == OP_FINISH && !stall) |=> !hold_valid)
    else $error("held result survived the end of an item");

endmodule
